@@ design/wrpc_pkg.sv @@
package wrpc_pkg;

   localparam int USERS_DEF  = 64;
   localparam int TIDS_DEF   = 8;
   localparam int PN_W       = 48;
   localparam int WINDOW     = 256;
   localparam int USER_W     = 6;
   localparam int TID_W      = 4;
   localparam int SLOT_W     = 6;
   localparam int CSR_IDX_W  = 2;
   localparam int CMDQ_DEPTH = 2;
   localparam int NSTORE     = 4;

   localparam logic [1:0] REQ_CHECK   = 2'd0;
   localparam logic [1:0] REQ_CLR_PTK = 2'd1;
   localparam logic [1:0] REQ_CLR_GTK = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_HW_WAPI = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CERTIFY = 2'd1;

   localparam logic [1:0] FTYPE_DATA = 2'd2;
   localparam logic [3:0] QOS_SUB_LO = 4'd8;
   localparam logic [3:0] QOS_SUB_HI = 4'd12;

   typedef enum logic [1:0] {
      OP_RESP,
      OP_CLR_PTK,
      OP_CLR_GTK,
      OP_CHECK
   } op_type;

   typedef enum logic [1:0] {
      ST_UQ,
      ST_MQ,
      ST_UN,
      ST_MN
   } store_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_PICK,
      BK_EVAL
   } back_state_type;

   typedef struct packed {
      op_type            op;
      logic              resp_accept;
      logic [USER_W-1:0] user_id;
      logic [SLOT_W-1:0] slot;
      store_type         store;
      logic              multicast;
      logic              cipher_wapi;
      logic [PN_W-1:0]   rx_pn;
   } cmd_type;

endpackage

@@ design/wrpc_front.sv @@
module wrpc_front
   import wrpc_pkg::*;
#(
   parameter int USERS = USERS_DEF,
   parameter int TIDS  = TIDS_DEF
) (
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [1:0]        req_type,
   input  logic [USER_W-1:0] req_user_id,
   input  logic [TID_W-1:0]  req_tid,
   input  logic [1:0]        req_frame_type,
   input  logic [3:0]        req_frame_subtype,
   input  logic              req_protected_flag,
   input  logic              req_retry_flag,
   input  logic              req_multicast,
   input  logic              req_exempt,
   input  logic [PN_W-1:0]   req_rx_pn,
   input  logic              req_cipher_wapi,
   input  logic              q_full,
   output logic              q_push,
   output cmd_type           q_cmd
);

   logic is_qos;
   logic user_ok;
   logic tid_ok;
   logic skip;

   // Every item is classified here into a plain response, a key clear or a store check.
   always_comb begin
      is_qos  = (req_frame_type == FTYPE_DATA) &&
                (req_frame_subtype inside {[QOS_SUB_LO:QOS_SUB_HI]});
      user_ok = 32'(req_user_id) < USERS;
      tid_ok  = 32'(req_tid) < TIDS;
      skip    = !req_protected_flag || req_retry_flag || req_exempt ||
                (is_qos && !tid_ok) || !user_ok;

      q_cmd             = '0;
      q_cmd.user_id     = req_user_id;
      q_cmd.multicast   = req_multicast;
      q_cmd.cipher_wapi = req_cipher_wapi;
      q_cmd.rx_pn       = req_rx_pn;
      if (is_qos) begin
         q_cmd.store = req_multicast ? ST_MQ : ST_UQ;
         q_cmd.slot  = req_multicast ? (SLOT_W'(TIDS) + SLOT_W'(req_tid)) : SLOT_W'(req_tid);
      end else begin
         q_cmd.store = req_multicast ? ST_MN : ST_UN;
         q_cmd.slot  = req_multicast ? SLOT_W'(2 * TIDS + 1) : SLOT_W'(2 * TIDS);
      end

      case (req_type)
         REQ_CHECK: begin
            q_cmd.op          = skip ? OP_RESP : OP_CHECK;
            q_cmd.resp_accept = 1'b1;
         end
         REQ_CLR_PTK: begin
            q_cmd.op          = user_ok ? OP_CLR_PTK : OP_RESP;
            q_cmd.resp_accept = 1'b0;
         end
         REQ_CLR_GTK: begin
            q_cmd.op          = user_ok ? OP_CLR_GTK : OP_RESP;
            q_cmd.resp_accept = 1'b0;
         end
         default: begin
            q_cmd.op          = OP_RESP;
            q_cmd.resp_accept = 1'b0;
         end
      endcase
   end

   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;

endmodule

@@ design/wrpc_cmdq.sv @@
module wrpc_cmdq
   import wrpc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output logic    pop_valid,
   output cmd_type pop_cmd
);

   localparam int PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
   localparam int CNT_W = $clog2(CMDQ_DEPTH + 1);

   cmd_type            entry_ff [CMDQ_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;

   assign full      = (cnt_ff == CNT_W'(CMDQ_DEPTH));
   assign pop_valid = (cnt_ff != '0);
   assign pop_cmd   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

@@ design/wrpc_back.sv @@
module wrpc_back
   import wrpc_pkg::*;
#(
   parameter int USERS = USERS_DEF,
   parameter int TIDS  = TIDS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    hw_wapi_en,
   input  logic    certify_en,
   input  logic    q_valid,
   input  cmd_type q_cmd,
   output logic    q_pop,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output logic    rsp_accept,
   output logic    rsp_checked,
   output logic    rsp_replay_detected,
   output logic    rsp_window_shifted
);

   localparam int UW    = (USERS > 1) ? $clog2(USERS) : 1;
   localparam int NSLOT = 2 * TIDS + 2;
   localparam int SW    = $clog2(NSLOT);

   typedef logic [NSLOT-1:0][PN_W-1:0] row_type;

   // One row per user: the QoS unicast slots, the QoS multicast slots,
   // then the unicast and multicast non-QoS slots.
   row_type mem [USERS];

   back_state_type             state_ff, state_in;
   cmd_type                    cmd_ff, cmd_in;
   row_type                    rd_row_ff;
   row_type                    row_ff, row_in;
   row_type                    wr_row;
   logic [PN_W-1:0]            last_ff, last_in;
   logic [NSTORE-1:0][USERS-1:0] vld_ff, vld_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       rsp_accept_ff, rsp_accept_in;
   logic                       rsp_checked_ff, rsp_checked_in;
   logic                       rsp_replay_ff, rsp_replay_in;
   logic                       rsp_shift_ff, rsp_shift_in;

   logic                       out_free;
   logic                       res_load;
   logic                       res_accept, res_checked, res_replay, res_shift;
   logic                       rd_en;
   logic                       wr_en;
   logic [UW-1:0]              q_user;
   logic [UW-1:0]              cur_user;
   logic [SW-1:0]              cur_slot;
   logic                       bypass, stale, wapi_even, bad, far;

   function automatic store_type slot_store(input int s);
      store_type st;
      if (s < TIDS) begin
         st = ST_UQ;
      end else if (s < 2 * TIDS) begin
         st = ST_MQ;
      end else if (s == 2 * TIDS) begin
         st = ST_UN;
      end else begin
         st = ST_MN;
      end
      return st;
   endfunction

   assign q_user   = UW'(q_cmd.user_id);
   assign cur_user = UW'(cmd_ff.user_id);
   assign cur_slot = SW'(cmd_ff.slot);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Entries of a store whose per-user flag is clear read as zero.
   always_comb begin
      for (int s = 0; s < NSLOT; s++) begin
         row_in[s] = vld_ff[slot_store(s)][cur_user] ? rd_row_ff[s] : '0;
      end
      last_in = row_in[cur_slot];
   end

   // Replay decision on the selected slot.
   always_comb begin
      bypass    = cmd_ff.cipher_wapi && !hw_wapi_en;
      stale     = (last_ff != '0) && (last_ff >= cmd_ff.rx_pn);
      wapi_even = cmd_ff.cipher_wapi && !cmd_ff.multicast && !cmd_ff.rx_pn[0];
      bad       = !bypass && (stale || wapi_even);
      far       = ({1'b0, cmd_ff.rx_pn} + (PN_W + 1)'(WINDOW)) < {1'b0, last_ff};
      wr_row           = row_ff;
      wr_row[cur_slot] = cmd_ff.rx_pn;
   end

   always_comb begin
      state_in    = state_ff;
      cmd_in      = cmd_ff;
      vld_in      = vld_ff;
      q_pop       = 1'b0;
      rd_en       = 1'b0;
      wr_en       = 1'b0;
      res_load    = 1'b0;
      res_accept  = 1'b0;
      res_checked = 1'b0;
      res_replay  = 1'b0;
      res_shift   = 1'b0;
      case (state_ff)
         BK_IDLE: begin
            if (q_valid) begin
               if (q_cmd.op == OP_CHECK) begin
                  q_pop    = 1'b1;
                  rd_en    = 1'b1;
                  cmd_in   = q_cmd;
                  state_in = BK_PICK;
               end else if (out_free) begin
                  q_pop      = 1'b1;
                  res_load   = 1'b1;
                  res_accept = q_cmd.resp_accept;
                  case (q_cmd.op)
                     OP_CLR_PTK: begin
                        vld_in[ST_UQ][q_user] = 1'b0;
                        vld_in[ST_MQ][q_user] = 1'b0;
                        vld_in[ST_UN][q_user] = 1'b0;
                     end
                     OP_CLR_GTK: begin
                        vld_in[ST_MN][q_user] = 1'b0;
                        vld_in[ST_UN][q_user] = 1'b0;
                     end
                     default: begin
                     end
                  endcase
               end
            end
         end
         BK_PICK: begin
            state_in = BK_EVAL;
         end
         BK_EVAL: begin
            if (out_free) begin
               res_load = 1'b1;
               wr_en    = !bad || far;
               if (bypass) begin
                  res_accept = 1'b1;
               end else if (bad) begin
                  res_accept  = certify_en;
                  res_checked = 1'b1;
                  res_replay  = 1'b1;
                  res_shift   = far;
               end else begin
                  res_accept  = 1'b1;
                  res_checked = 1'b1;
               end
               if (wr_en) begin
                  vld_in[cmd_ff.store][cur_user] = 1'b1;
               end
               state_in = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_accept_in  = rsp_accept_ff;
      rsp_checked_in = rsp_checked_ff;
      rsp_replay_in  = rsp_replay_ff;
      rsp_shift_in   = rsp_shift_ff;
      if (res_load) begin
         rsp_valid_in   = 1'b1;
         rsp_accept_in  = res_accept;
         rsp_checked_in = res_checked;
         rsp_replay_in  = res_replay;
         rsp_shift_in   = res_shift;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         vld_ff       <= vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff         <= cmd_in;
      row_ff         <= row_in;
      last_ff        <= last_in;
      rsp_accept_ff  <= rsp_accept_in;
      rsp_checked_ff <= rsp_checked_in;
      rsp_replay_ff  <= rsp_replay_in;
      rsp_shift_ff   <= rsp_shift_in;
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_row_ff <= mem[q_user];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[cur_user] <= wr_row;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_accept          = rsp_accept_ff;
   assign rsp_checked         = rsp_checked_ff;
   assign rsp_replay_detected = rsp_replay_ff;
   assign rsp_window_shifted  = rsp_shift_ff;

`ifndef SYNTHESIS
   a_check_walk: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_IDLE && q_pop && q_cmd.op == OP_CHECK) |=>
         (state_ff == BK_PICK) ##1 (state_ff == BK_EVAL))
      else $error("check item did not walk through pick and eval");

   a_write_sets_valid: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> vld_ff[cmd_ff.store][cur_user])
      else $error("written store not marked valid");

   a_no_result_overwrite: assert property (@(posedge clock) disable iff (reset)
      res_load |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result register overwritten while stalled");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("pop from empty command queue");
`endif

endmodule

@@ design/wlan_rx_replay_pn_check_core.sv @@
// Channel   Direction  Handshake               Payload
// req_*     in         req_valid / req_stall   req_type, user, tid, frame control bits, rx_pn
// rsp_*     out        rsp_valid / rsp_stall   accept, checked, replay_detected, window_shifted
// csr_*     in         csr_valid / csr_ready   csr_index, csr_wdata
//
// A check item that reaches the store reads the user's row from the PN memory,
// picks the slot, then compares and writes back once the result register is free.
// Skipped, clear and unused items are answered from idle without a memory read.
// Reset clears per-user valid flags at once, so no clearing pass is needed.
// A two-entry command queue lets the front accept while rsp_stall holds, until full.

module wlan_rx_replay_pn_check_core
   import wrpc_pkg::*;
#(
   parameter int USERS = USERS_DEF,
   parameter int TIDS  = TIDS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,

   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [1:0]           req_type,
   input  logic [USER_W-1:0]    req_user_id,
   input  logic [TID_W-1:0]     req_tid,
   input  logic [1:0]           req_frame_type,
   input  logic [3:0]           req_frame_subtype,
   input  logic                 req_protected_flag,
   input  logic                 req_retry_flag,
   input  logic                 req_multicast,
   input  logic                 req_exempt,
   input  logic [PN_W-1:0]      req_rx_pn,
   input  logic                 req_cipher_wapi,

   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_accept,
   output logic                 rsp_checked,
   output logic                 rsp_replay_detected,
   output logic                 rsp_window_shifted,

   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic                 csr_wdata
);

   // Control registers. Writes arrive only while the block is idle (the user must
   // ensure it; the block does not enforce it), so they feed the back end directly.
   logic    hw_wapi_ff, hw_wapi_in;
   logic    certify_ff, certify_in;

   // Front end to command queue to back end.
   logic    q_full;
   logic    q_push;
   cmd_type q_push_cmd;
   logic    q_pop;
   logic    q_valid;
   cmd_type q_cmd;

   assign csr_ready = 1'b1;

   always_comb begin
      hw_wapi_in = hw_wapi_ff;
      certify_in = certify_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_HW_WAPI: hw_wapi_in = csr_wdata;
            CSR_CERTIFY: certify_in = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hw_wapi_ff <= 1'b0;
         certify_ff <= 1'b0;
      end else begin
         hw_wapi_ff <= hw_wapi_in;
         certify_ff <= certify_in;
      end
   end

   // The front end classifies each item and picks the PN slot.
   wrpc_front #(
      .USERS (USERS),
      .TIDS  (TIDS)
   ) u_front (
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_type           (req_type),
      .req_user_id        (req_user_id),
      .req_tid            (req_tid),
      .req_frame_type     (req_frame_type),
      .req_frame_subtype  (req_frame_subtype),
      .req_protected_flag (req_protected_flag),
      .req_retry_flag     (req_retry_flag),
      .req_multicast      (req_multicast),
      .req_exempt         (req_exempt),
      .req_rx_pn          (req_rx_pn),
      .req_cipher_wapi    (req_cipher_wapi),
      .q_full             (q_full),
      .q_push             (q_push),
      .q_cmd              (q_push_cmd)
   );

   wrpc_cmdq u_cmdq (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_cmd  (q_push_cmd),
      .full      (q_full),
      .pop       (q_pop),
      .pop_valid (q_valid),
      .pop_cmd   (q_cmd)
   );

   // The back end owns the PN memory, its valid flags and the result register.
   wrpc_back #(
      .USERS (USERS),
      .TIDS  (TIDS)
   ) u_back (
      .clock               (clock),
      .reset               (reset),
      .hw_wapi_en          (hw_wapi_ff),
      .certify_en          (certify_ff),
      .q_valid             (q_valid),
      .q_cmd               (q_cmd),
      .q_pop               (q_pop),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_accept          (rsp_accept),
      .rsp_checked         (rsp_checked),
      .rsp_replay_detected (rsp_replay_detected),
      .rsp_window_shifted  (rsp_window_shifted)
   );

endmodule
